[rtl/core/ntc_otp_pkg.sv]
// Shared types and constants of the thermistor over-temperature debounce block.
package ntc_otp_pkg;

  localparam int unsigned CHANNELS = 32;
  localparam int unsigned LEVELS   = 2;
  localparam int unsigned ENTRIES  = CHANNELS * LEVELS;
  localparam int unsigned ENTRY_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int unsigned CH_W     = 5;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 16;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_SETTING   = 2'd1,
    ST_TRIPPED   = 2'd2,
    ST_RELEASING = 2'd3
  } status_e;

  // Low two bits of a register index select the field, the bit above selects the level.
  typedef enum logic [1:0] {
    FIELD_SET_THR  = 2'd0,
    FIELD_SET_TIME = 2'd1,
    FIELD_REL_THR  = 2'd2,
    FIELD_REL_TIME = 2'd3
  } cfg_field_e;

  typedef struct packed {
    status_e           status;
    logic [CNT_W-1:0]  set_cnt;
    logic [CNT_W-1:0]  rel_cnt;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[rtl/core/ntc_otp_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module ntc_otp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read of the entry being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ntc_overtemp_set_release_debounce.sv]
// A result passes through the stage 1 and output registers after its sample is accepted.
// One sample per cycle while the output is not stalled; the entry RAM is read in the
// accept cycle and written back as the sample leaves stage 1, with a forwarding register
// covering back-to-back samples on the same channel and level.
// Reset clears the configuration, the per-entry valid bits (an unwritten entry reads
// as idle with zero counters) and the pipeline; no clearing pass is needed.
module ntc_overtemp_set_release_debounce (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ntc_otp_pkg::CH_W-1:0]        channel_i,
  input  logic                                level_i,
  input  logic [ntc_otp_pkg::SAMPLE_W-1:0]    sample_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic                                set_event_o,
  output logic                                release_event_o,
  output logic [ntc_otp_pkg::CH_W-1:0]        channel_out_o,
  output logic                                level_out_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ntc_otp_pkg::CFG_AW-1:0]      cfg_index_i,
  input  logic [ntc_otp_pkg::CFG_DW-1:0]      cfg_data_i
);

  localparam int unsigned AW = ntc_otp_pkg::ENTRY_AW;

  // Configuration registers
  logic [ntc_otp_pkg::SAMPLE_W-1:0] set_thr_q  [ntc_otp_pkg::LEVELS];
  logic [ntc_otp_pkg::CNT_W-1:0]    set_time_q [ntc_otp_pkg::LEVELS];
  logic [ntc_otp_pkg::SAMPLE_W-1:0] rel_thr_q  [ntc_otp_pkg::LEVELS];
  logic [ntc_otp_pkg::CNT_W-1:0]    rel_time_q [ntc_otp_pkg::LEVELS];

  logic                   cfg_we;
  logic                   cfg_lv;
  ntc_otp_pkg::cfg_field_e cfg_field;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && (32'(cfg_index_i[2]) < ntc_otp_pkg::LEVELS);
  assign cfg_lv      = cfg_index_i[2];
  assign cfg_field   = ntc_otp_pkg::cfg_field_e'(cfg_index_i[1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ntc_otp_pkg::LEVELS; i++) begin
        set_thr_q[i]  <= '0;
        set_time_q[i] <= '0;
        rel_thr_q[i]  <= '0;
        rel_time_q[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_field)
        ntc_otp_pkg::FIELD_SET_THR:  set_thr_q[cfg_lv]  <= cfg_data_i;
        ntc_otp_pkg::FIELD_SET_TIME: set_time_q[cfg_lv] <= cfg_data_i[ntc_otp_pkg::CNT_W-1:0];
        ntc_otp_pkg::FIELD_REL_THR:  rel_thr_q[cfg_lv]  <= cfg_data_i;
        ntc_otp_pkg::FIELD_REL_TIME: rel_time_q[cfg_lv] <= cfg_data_i[ntc_otp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_adv, in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !out_free);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Entry address and range check of the incoming sample
  logic          in_range;
  logic [AW-1:0] in_addr;

  assign in_range = (32'(channel_i) < ntc_otp_pkg::CHANNELS) &&
                    (32'(level_i) < ntc_otp_pkg::LEVELS);
  assign in_addr  = level_i ? AW'(ntc_otp_pkg::CHANNELS + 32'(channel_i)) : AW'(channel_i);

  // Stage 1 registers, loaded with each accepted transaction
  logic [ntc_otp_pkg::CH_W-1:0]     s1_ch_q;
  logic                             s1_lv_q;
  logic [ntc_otp_pkg::SAMPLE_W-1:0] s1_smp_q;
  logic [AW-1:0]                    s1_addr_q;
  logic                             s1_inr_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ch_q   <= channel_i;
      s1_lv_q   <= level_i;
      s1_smp_q  <= sample_i;
      s1_addr_q <= in_addr;
      s1_inr_q  <= in_range;
    end
  end

  // Entry memory, valid bits and write-back forwarding
  logic                               ram_we;
  logic [ntc_otp_pkg::ENTRY_W-1:0]    ram_rdata;
  ntc_otp_pkg::entry_t                cur, nxt;
  logic [ntc_otp_pkg::ENTRIES-1:0]    entry_valid_q;
  logic                               fwd_valid_q;
  logic [AW-1:0]                      fwd_addr_q;
  ntc_otp_pkg::entry_t                fwd_data_q;

  assign ram_we = s1_adv && s1_inr_q;

  ntc_otp_ram #(
    .WIDTH (ntc_otp_pkg::ENTRY_W),
    .DEPTH (ntc_otp_pkg::ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (nxt),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      fwd_valid_q   <= 1'b0;
    end else if (ram_we) begin
      entry_valid_q[s1_addr_q] <= 1'b1;
      fwd_valid_q              <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= nxt;
    end
  end

  // The forwarding register always holds the latest write, so a hit is never stale.
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr_q)) begin
      cur = fwd_data_q;
    end else if (entry_valid_q[s1_addr_q]) begin
      cur = ntc_otp_pkg::entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  // Set phase, then release phase, on the same entry
  logic                          over, recovered;
  logic                          set_ev, rel_ev;
  logic [ntc_otp_pkg::CNT_W-1:0] set_inc, rel_inc;
  ntc_otp_pkg::status_e          mid_st;

  always_comb begin
    over      = s1_smp_q <= set_thr_q[s1_lv_q];
    recovered = s1_smp_q >= rel_thr_q[s1_lv_q];
    set_inc   = cur.set_cnt + ntc_otp_pkg::CNT_W'(1);
    rel_inc   = cur.rel_cnt + ntc_otp_pkg::CNT_W'(1);
    nxt       = cur;
    set_ev    = 1'b0;
    rel_ev    = 1'b0;

    if (over && (set_time_q[s1_lv_q] != '0)) begin
      case (cur.status)
        ntc_otp_pkg::ST_IDLE: begin
          nxt.status  = ntc_otp_pkg::ST_SETTING;
          nxt.set_cnt = 8'd1;
        end
        ntc_otp_pkg::ST_SETTING: begin
          if (set_inc >= set_time_q[s1_lv_q]) begin
            nxt.status  = ntc_otp_pkg::ST_TRIPPED;
            nxt.set_cnt = '0;
            set_ev      = 1'b1;
          end else begin
            nxt.set_cnt = set_inc;
          end
        end
        default: ;
      endcase
    end else if (cur.status == ntc_otp_pkg::ST_SETTING) begin
      nxt.status = ntc_otp_pkg::ST_IDLE;
    end

    mid_st = nxt.status;
    if (recovered && (rel_time_q[s1_lv_q] != '0)) begin
      case (mid_st)
        ntc_otp_pkg::ST_TRIPPED: begin
          nxt.status  = ntc_otp_pkg::ST_RELEASING;
          nxt.rel_cnt = 8'd1;
        end
        ntc_otp_pkg::ST_RELEASING: begin
          if (rel_inc >= rel_time_q[s1_lv_q]) begin
            nxt.status  = ntc_otp_pkg::ST_IDLE;
            nxt.rel_cnt = '0;
            rel_ev      = 1'b1;
          end else begin
            nxt.rel_cnt = rel_inc;
          end
        end
        default: ;
      endcase
    end else if (mid_st == ntc_otp_pkg::ST_RELEASING) begin
      nxt.status = ntc_otp_pkg::ST_TRIPPED;
    end
  end

  // Output register
  logic [1:0]                   out_status_q;
  logic                         out_set_ev_q, out_rel_ev_q;
  logic [ntc_otp_pkg::CH_W-1:0] out_ch_q;
  logic                         out_lv_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= s1_inr_q ? nxt.status : ntc_otp_pkg::ST_IDLE;
      out_set_ev_q <= s1_inr_q && set_ev;
      out_rel_ev_q <= s1_inr_q && rel_ev;
      out_ch_q     <= s1_ch_q;
      out_lv_q     <= s1_lv_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign set_event_o     = out_set_ev_q;
  assign release_event_o = out_rel_ev_q;
  assign channel_out_o   = out_ch_q;
  assign level_out_o     = out_lv_q;

endmodule

[sim/ntc_overtemp_set_release_debounce_tb.sv]
// Self-checking testbench for the thermistor over-temperature set and release debounce block.
module ntc_overtemp_set_release_debounce_tb;
  import ntc_otp_pkg::*;

  typedef struct packed {
    status_e           status;
    logic              set_ev;
    logic              rel_ev;
    logic [CH_W-1:0]   ch;
    logic              lv;
  } otp_result_t;

  typedef enum int {KIND_HOT, KIND_COOL, KIND_MILD, KIND_NOISE} sample_kind_e;

  // Tracks the debounce state of every entry and holds the results still awaited.
  class debounce_tracker;
    logic [SAMPLE_W-1:0] set_thr [LEVELS];
    logic [CNT_W-1:0]    set_time [LEVELS];
    logic [SAMPLE_W-1:0] rel_thr [LEVELS];
    logic [CNT_W-1:0]    rel_time [LEVELS];
    status_e             status_tbl [ENTRIES];
    logic [CNT_W-1:0]    set_cnt [ENTRIES];
    logic [CNT_W-1:0]    rel_cnt [ENTRIES];
    otp_result_t         awaited [$];
    int                  errors;
    int                  checked;
    int                  samples;
    int                  set_events;
    int                  release_events;

    function new();
      foreach (status_tbl[i]) begin
        status_tbl[i] = ST_IDLE;
        set_cnt[i]    = '0;
        rel_cnt[i]    = '0;
      end
      foreach (set_thr[l]) begin
        set_thr[l]  = '0;
        set_time[l] = '0;
        rel_thr[l]  = '0;
        rel_time[l] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      logic lv;
      lv = idx[CFG_AW-1];
      case (cfg_field_e'(idx[1:0]))
        FIELD_SET_THR:  set_thr[lv]  = data;
        FIELD_SET_TIME: set_time[lv] = data[CNT_W-1:0];
        FIELD_REL_THR:  rel_thr[lv]  = data;
        default:        rel_time[lv] = data[CNT_W-1:0];
      endcase
    endfunction

    function void note_sample(logic [CH_W-1:0] ch, logic lv, logic [SAMPLE_W-1:0] smp);
      int unsigned      e;
      logic             over;
      logic             recovered;
      logic [CNT_W-1:0] c;
      otp_result_t      r;
      r = '{status: ST_IDLE, set_ev: 1'b0, rel_ev: 1'b0, ch: ch, lv: lv};
      samples++;
      if (ch < CHANNELS && lv < LEVELS) begin
        e         = lv * CHANNELS + ch;
        over      = smp <= set_thr[lv];
        recovered = smp >= rel_thr[lv];
        r.status  = status_tbl[e];
        // The set phase runs first; the release phase then sees its outcome.
        if (over && set_time[lv] != 0) begin
          if (r.status == ST_IDLE) begin
            r.status   = ST_SETTING;
            set_cnt[e] = CNT_W'(1);
          end else if (r.status == ST_SETTING) begin
            c          = set_cnt[e] + CNT_W'(1);
            set_cnt[e] = c;
            if (c >= set_time[lv]) begin
              r.status   = ST_TRIPPED;
              set_cnt[e] = '0;
              r.set_ev   = 1'b1;
            end
          end
        end else if (r.status == ST_SETTING) begin
          r.status = ST_IDLE;
        end
        if (recovered && rel_time[lv] != 0) begin
          if (r.status == ST_TRIPPED) begin
            r.status   = ST_RELEASING;
            rel_cnt[e] = CNT_W'(1);
          end else if (r.status == ST_RELEASING) begin
            c          = rel_cnt[e] + CNT_W'(1);
            rel_cnt[e] = c;
            if (c >= rel_time[lv]) begin
              r.status   = ST_IDLE;
              rel_cnt[e] = '0;
              r.rel_ev   = 1'b1;
            end
          end
        end else if (r.status == ST_RELEASING) begin
          r.status = ST_TRIPPED;
        end
        status_tbl[e] = r.status;
      end
      set_events     += int'(r.set_ev);
      release_events += int'(r.rel_ev);
      awaited.push_back(r);
    endfunction

    function void check_result(otp_result_t got);
      otp_result_t exp;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Result with nothing awaited: status %0d set %0b release %0b ch %0d lv %0d",
                   got.status, got.set_ev, got.rel_ev, got.ch, got.lv);
        return;
      end
      exp = awaited.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch: expected status %0d set %0b release %0b ch %0d lv %0d",
                   exp.status, exp.set_ev, exp.rel_ev, exp.ch, exp.lv);
          $display("          got      status %0d set %0b release %0b ch %0d lv %0d",
                   got.status, got.set_ev, got.rel_ev, got.ch, got.lv);
        end
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CH_W-1:0]     channel_i;
  logic                level_i;
  logic [SAMPLE_W-1:0] sample_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          status_o;
  logic                set_event_o;
  logic                release_event_o;
  logic [CH_W-1:0]     channel_out_o;
  logic                level_out_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_AW-1:0]   cfg_index_i;
  logic [CFG_DW-1:0]   cfg_data_i;

  ntc_overtemp_set_release_debounce u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .channel_i       (channel_i),
    .level_i         (level_i),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .set_event_o     (set_event_o),
    .release_event_o (release_event_o),
    .channel_out_o   (channel_out_o),
    .level_out_o     (level_out_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  debounce_tracker   tracker = new();
  bit                steady;
  int                settings;
  logic [CFG_DW-1:0] reg_vals [8];
  logic [CH_W-1:0]   hot_ch [4];
  otp_result_t       seen_result;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("ntc_overtemp_set_release_debounce_tb NOT OK");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 32);
  end

  // Both channels are sampled on the edge itself, before any driven value moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        tracker.note_sample(channel_i, level_i, sample_i);
      if (out_valid_o && !out_stall_i) begin
        seen_result.status = status_e'(status_o);
        seen_result.set_ev = set_event_o;
        seen_result.rel_ev = release_event_o;
        seen_result.ch     = channel_out_o;
        seen_result.lv     = level_out_o;
        tracker.check_result(seen_result);
      end
    end
  end

  task automatic send_sample(input logic [CH_W-1:0] ch, input logic lv,
                             input logic [SAMPLE_W-1:0] smp);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    level_i    <= lv;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Waits until every awaited result has been seen and the pipeline has drained.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_registers();
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CFG_AW'(i);
      cfg_data_i  <= reg_vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.write_reg(CFG_AW'(i), reg_vals[i]);
    end
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  function automatic void set_level(logic lv, logic [CFG_DW-1:0] sthr, logic [CFG_DW-1:0] stime,
                                    logic [CFG_DW-1:0] rthr, logic [CFG_DW-1:0] rtime);
    reg_vals[{lv, FIELD_SET_THR}]  = sthr;
    reg_vals[{lv, FIELD_SET_TIME}] = stime;
    reg_vals[{lv, FIELD_REL_THR}]  = rthr;
    reg_vals[{lv, FIELD_REL_TIME}] = rtime;
  endfunction

  // Mostly short debounce times so that trips happen; the upper byte is junk the block drops.
  function automatic logic [CFG_DW-1:0] random_time();
    int unsigned r;
    int unsigned t;
    r = $urandom_range(9);
    if (r == 0) t = 0;
    else if (r == 1) t = $urandom_range(255, 7);
    else t = $urandom_range(6, 1);
    return {8'($urandom), 8'(t)};
  endfunction

  function automatic void randomise_registers();
    int unsigned sthr;
    int unsigned rthr;
    for (int l = 0; l < LEVELS; l++) begin
      sthr = $urandom_range(45000, 500);
      rthr = ($urandom_range(4) == 0) ? $urandom_range(sthr, 0) : $urandom_range(65535, sthr);
      set_level(l[0], 16'(sthr), random_time(), 16'(rthr), random_time());
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(logic lv, sample_kind_e kind);
    int unsigned sthr;
    int unsigned rthr;
    sthr = 32'(reg_vals[{lv, FIELD_SET_THR}]);
    rthr = 32'(reg_vals[{lv, FIELD_REL_THR}]);
    case (kind)
      KIND_HOT:  return SAMPLE_W'($urandom_range(sthr, 0));
      KIND_COOL: return SAMPLE_W'($urandom_range(65535, rthr));
      KIND_MILD: return (rthr > sthr + 1) ? SAMPLE_W'($urandom_range(rthr - 1, sthr + 1))
                                          : SAMPLE_W'($urandom);
      default:   return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic run_directed();
    // Both directions are disabled by the reset values.
    send_sample(5'd0, 1'b0, 16'h0000);
    send_sample(5'd31, 1'b1, 16'hFFFF);
    settle();
    set_level(1'b0, 16'd1000, 16'd1, 16'd2000, 16'd1);
    set_level(1'b1, 16'd3000, 16'd2, 16'd1000, 16'd2);
    program_registers();
    // A count of one still needs a second sample, in both directions.
    send_sample(5'd3, 1'b0, 16'd500);
    send_sample(5'd3, 1'b0, 16'd500);
    send_sample(5'd3, 1'b0, 16'd2500);
    send_sample(5'd3, 1'b0, 16'd2500);
    // A setting entry drops back to idle on a sample between the thresholds.
    send_sample(5'd3, 1'b0, 16'd500);
    send_sample(5'd3, 1'b0, 16'd1500);
    send_sample(5'd3, 1'b0, 16'h0000);
    send_sample(5'd3, 1'b0, 16'h0000);
    // A releasing entry falls back to tripped, then releases properly.
    send_sample(5'd3, 1'b0, 16'hFFFF);
    send_sample(5'd3, 1'b0, 16'd1500);
    send_sample(5'd3, 1'b0, 16'd2000);
    send_sample(5'd3, 1'b0, 16'd2000);
    // Overlapping thresholds: the tripping sample also starts the release.
    send_sample(5'd31, 1'b1, 16'd2000);
    send_sample(5'd31, 1'b1, 16'd2000);
    send_sample(5'd31, 1'b1, 16'd2000);
    send_sample(5'd0, 1'b1, 16'hFFFF);
    settle();
  endtask

  task automatic run_extreme_phase();
    logic [SAMPLE_W-1:0] smp;
    // Level 0 needs the longest counts; level 1 sees every sample as recovered.
    set_level(1'b0, 16'hFFFF, 16'd255, 16'hFFFF, 16'd255);
    set_level(1'b1, 16'h0000, 16'd1, 16'h0000, 16'd1);
    program_registers();
    for (int j = 0; j < 512; j++) begin
      if (j < 255) smp = SAMPLE_W'($urandom_range(65534, 0));
      else if (j < 510) smp = 16'hFFFF;
      else smp = SAMPLE_W'($urandom);
      send_sample(5'd7, 1'b0, smp);
      if (j % 8 == 0)
        send_sample(($urandom_range(1) == 0) ? 5'd7 : 5'($urandom), 1'b1,
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000);
    end
    settle();
  endtask

  task automatic run_random_phase(input int n_items);
    int              done;
    int              run;
    logic [CH_W-1:0] ch;
    logic            lv;
    sample_kind_e    kind;
    done = 0;
    while (done < n_items) begin
      ch   = ($urandom_range(3) == 0) ? 5'($urandom) : hot_ch[$urandom_range(3)];
      lv   = 1'($urandom);
      run  = $urandom_range(8, 1);
      case ($urandom_range(9))
        0, 1, 2, 3: kind = KIND_HOT;
        4, 5, 6, 7: kind = KIND_COOL;
        8:          kind = KIND_MILD;
        default:    kind = KIND_NOISE;
      endcase
      for (int k = 0; k < run; k++) begin
        send_sample(ch, lv, pick_sample(lv, kind));
        done++;
      end
    end
    settle();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    channel_i   <= '0;
    level_i     <= 1'b0;
    sample_i    <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    steady       = 1'b0;
    settings     = 0;
    foreach (reg_vals[i]) reg_vals[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_extreme_phase();
    for (int p = 0; p < 5; p++) begin
      randomise_registers();
      foreach (hot_ch[i]) hot_ch[i] = 5'($urandom);
      program_registers();
      steady = (p == 1);
      run_random_phase(165);
      steady = 1'b0;
    end

    $display("Covered %0d sample transactions under %0d register settings, %0d results compared.",
             tracker.samples, settings, tracker.checked);
    $display("Trips %0d, releases %0d, mismatches %0d, results still awaited %0d.",
             tracker.set_events, tracker.release_events, tracker.errors, tracker.outstanding());
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("ntc_overtemp_set_release_debounce_tb OK");
    end else begin
      $display("ntc_overtemp_set_release_debounce_tb NOT OK");
    end
    $finish;
  end

endmodule

[ntc_overtemp_set_release_debounce.f]
rtl/core/ntc_otp_pkg.sv
rtl/core/ntc_otp_ram.sv
rtl/core/ntc_overtemp_set_release_debounce.sv
sim/ntc_overtemp_set_release_debounce_tb.sv
